// ===== src/ccpp_pkg.sv =====
// shared types, constants and functions for the constant pool parser
// no dependencies; imported by every module of the block
package ccpp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 16;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned AccW    = 64;
  localparam int unsigned FieldW  = 4;
  localparam int unsigned OutDataW = 104;  // 99 payload bits padded to whole bytes
  localparam int unsigned AddrW   = 3;

  // status codes
  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StTrunc  = 2'd1;
  localparam logic [1:0] StBadTag = 2'd2;

  // class-file entry tags
  localparam logic [ByteW-1:0] TagUtf8           = 8'd1;
  localparam logic [ByteW-1:0] TagInteger        = 8'd3;
  localparam logic [ByteW-1:0] TagFloat          = 8'd4;
  localparam logic [ByteW-1:0] TagLong           = 8'd5;
  localparam logic [ByteW-1:0] TagDouble         = 8'd6;
  localparam logic [ByteW-1:0] TagClass          = 8'd7;
  localparam logic [ByteW-1:0] TagString         = 8'd8;
  localparam logic [ByteW-1:0] TagFieldref       = 8'd9;
  localparam logic [ByteW-1:0] TagMethodref      = 8'd10;
  localparam logic [ByteW-1:0] TagIfaceMethodref = 8'd11;
  localparam logic [ByteW-1:0] TagNameAndType    = 8'd12;
  localparam logic [ByteW-1:0] TagMethodHandle   = 8'd15;
  localparam logic [ByteW-1:0] TagMethodType     = 8'd16;
  localparam logic [ByteW-1:0] TagInvokeDynamic  = 8'd18;

  // register index of pool_count
  localparam logic RegPoolCount = 1'b0;

  typedef enum logic [3:0] {
    PH_TAG    = 4'b0001,
    PH_FIELDS = 4'b0010,
    PH_TEXT   = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0]  tag;
    logic [CountW-1:0] index;
    logic [ValueW-1:0] first;
    logic [ValueW-1:0] second;
    logic [ByteW-1:0]  text;
    logic              is_text;
    logic              last;
    logic              done;
    logic [1:0]        status;
  } res_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             start;
    logic             eod;
  } in_beat_t;

  // field bytes following a tag; zero flags an unknown tag
  function automatic logic [FieldW-1:0] field_size(input logic [ByteW-1:0] tag);
    logic [FieldW-1:0] sz;
    begin
      case (tag)
        TagUtf8, TagClass, TagString, TagMethodType:        sz = 4'd2;
        TagInteger, TagFloat, TagFieldref, TagMethodref,
        TagIfaceMethodref, TagNameAndType, TagInvokeDynamic: sz = 4'd4;
        TagLong, TagDouble:                                  sz = 4'd8;
        TagMethodHandle:                                     sz = 4'd3;
        default:                                             sz = 4'd0;
      endcase
      return sz;
    end
  endfunction

endpackage

// ===== src/ccpp_in_reg.sv =====
// input register stage for the constant pool parser
// depends on ccpp_pkg
module ccpp_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  ccpp_pkg::in_beat_t beat_i,
  output logic               valid_o,
  input  logic               take_i,
  output ccpp_pkg::in_beat_t beat_o
);
  import ccpp_pkg::*;

  logic     valid_q, valid_d;
  in_beat_t beat_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;
endmodule

// ===== src/ccpp_parse.sv =====
// parser state and per-byte step logic for the constant pool parser
// depends on ccpp_pkg
module ccpp_parse (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  ccpp_pkg::in_beat_t             beat_i,
  input  logic [ccpp_pkg::CountW-1:0]    pool_count_i,
  output logic                           res_valid_o,
  output ccpp_pkg::res_t                 res_o
);
  import ccpp_pkg::*;

  phase_e             phase_q, phase_d, phase_s;
  logic [ByteW-1:0]   tag_q, tag_d;
  logic [FieldW-1:0]  fbl_q, fbl_d, fbl_s, fbl_m, fsz;
  logic [AccW-1:0]    acc_q, acc_d, acc_s, acc_n;
  logic [CountW-1:0]  tbl_q, tbl_d, tbl_s, tbl_m;
  logic [CountW-1:0]  entry_q, entry_d, entry_s;
  logic               halted_q, halted_d, halted_s;
  logic               done;
  logic [ValueW-1:0]  first, second;

  always_comb begin
    phase_s  = beat_i.start ? PH_TAG : phase_q;
    entry_s  = beat_i.start ? CountW'(1) : entry_q;
    halted_s = beat_i.start ? 1'b0 : halted_q;
    fbl_s    = beat_i.start ? '0 : fbl_q;
    acc_s    = beat_i.start ? '0 : acc_q;
    tbl_s    = beat_i.start ? '0 : tbl_q;

    acc_n = {acc_s[AccW-ByteW-1:0], beat_i.data};
    fbl_m = fbl_s - FieldW'(1);
    tbl_m = tbl_s - CountW'(1);
    fsz   = field_size(beat_i.data);
    done  = ({1'b0, entry_s} + {{CountW{1'b0}}, 1'b1}) >= {1'b0, pool_count_i};

    // decode of the completed field bytes
    first  = '0;
    second = '0;
    case (tag_q)
      TagInteger, TagFloat: first = acc_n[31:0];
      TagLong, TagDouble: begin
        first  = acc_n[63:32];
        second = acc_n[31:0];
      end
      TagMethodHandle: begin
        first  = {24'd0, acc_n[23:16]};
        second = {16'd0, acc_n[15:0]};
      end
      TagFieldref, TagMethodref, TagIfaceMethodref, TagNameAndType,
      TagInvokeDynamic: begin
        first  = {16'd0, acc_n[31:16]};
        second = {16'd0, acc_n[15:0]};
      end
      default: first = {16'd0, acc_n[15:0]};
    endcase

    phase_d  = phase_s;
    tag_d    = tag_q;
    fbl_d    = fbl_s;
    acc_d    = acc_s;
    tbl_d    = tbl_s;
    entry_d  = entry_s;
    halted_d = halted_s;

    res_valid_o = 1'b0;
    res_o        = '0;
    res_o.tag    = tag_q;
    res_o.index  = entry_s;
    res_o.status = StOk;

    if (!halted_s) begin
      unique case (phase_s)
        PH_TAG: begin
          if (entry_s < pool_count_i) begin
            tag_d     = beat_i.data;
            res_o.tag = beat_i.data;
            fbl_d     = fsz;
            acc_d     = '0;
            if (fsz == '0) begin
              res_valid_o  = 1'b1;
              res_o.last   = 1'b1;
              res_o.status = StBadTag;
              halted_d     = 1'b1;
            end else begin
              phase_d = PH_FIELDS;
              if (beat_i.eod) begin
                res_valid_o  = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = StTrunc;
                halted_d     = 1'b1;
              end
            end
          end
        end
        PH_FIELDS: begin
          acc_d = acc_n;
          fbl_d = fbl_m;
          if (fbl_m != '0) begin
            if (beat_i.eod) begin
              res_valid_o  = 1'b1;
              res_o.last   = 1'b1;
              res_o.status = StTrunc;
              halted_d     = 1'b1;
            end
          end else if (tag_q == TagUtf8 && first != '0) begin
            // utf8 header, text bytes follow
            tbl_d        = first[CountW-1:0];
            phase_d      = PH_TEXT;
            res_valid_o  = 1'b1;
            res_o.first  = first;
            res_o.last   = beat_i.eod;
            res_o.status = beat_i.eod ? StTrunc : StOk;
            halted_d     = beat_i.eod;
          end else begin
            // a finished entry reports the slot after the advance
            entry_d      = entry_s + CountW'(1);
            phase_d      = done ? PH_IDLE : PH_TAG;
            res_valid_o  = 1'b1;
            res_o.index  = entry_d;
            res_o.first  = first;
            res_o.second = second;
            res_o.last   = 1'b1;
            res_o.done   = done;
            res_o.status = (beat_i.eod && !done) ? StTrunc : StOk;
            halted_d     = beat_i.eod && !done;
          end
        end
        PH_TEXT: begin
          tbl_d         = tbl_m;
          res_valid_o   = 1'b1;
          res_o.text    = beat_i.data;
          res_o.is_text = 1'b1;
          if (tbl_m != '0) begin
            res_o.last   = beat_i.eod;
            res_o.status = beat_i.eod ? StTrunc : StOk;
            halted_d     = beat_i.eod;
          end else begin
            entry_d      = entry_s + CountW'(1);
            phase_d      = done ? PH_IDLE : PH_TAG;
            res_o.index  = entry_d;
            res_o.last   = 1'b1;
            res_o.done   = done;
            res_o.status = (beat_i.eod && !done) ? StTrunc : StOk;
            halted_d     = beat_i.eod && !done;
          end
        end
        PH_IDLE: begin
        end
        default: begin
        end
      endcase
    end
    res_valid_o = res_valid_o && step_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TAG;
      tag_q    <= '0;
      fbl_q    <= '0;
      acc_q    <= '0;
      tbl_q    <= '0;
      entry_q  <= CountW'(1);
      halted_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      tag_q    <= tag_d;
      fbl_q    <= fbl_d;
      acc_q    <= acc_d;
      tbl_q    <= tbl_d;
      entry_q  <= entry_d;
      halted_q <= halted_d;
    end
  end
endmodule

// ===== src/ccpp_out_reg.sv =====
// result register for the constant pool parser
// depends on ccpp_pkg
module ccpp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  ccpp_pkg::res_t res_i,
  input  logic           ready_i,
  output logic           free_o,
  output logic           valid_o,
  output ccpp_pkg::res_t res_o
);
  import ccpp_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule

// ===== src/class_constant_pool_parser_core.sv =====
// an accepted byte's record is registered in the input reg, then in the result reg
// throughput: one byte per cycle while the result register has room;
// every byte needs only a single state update
// a byte is taken while a result waits, as long as the result register drains that cycle
// reset: asynchronous active low; parser returns to expecting a tag at entry one,
// pool_count clears to zero, both pipeline registers empty
// top level of the constant pool parser; depends on ccpp_pkg and the ccpp_* modules
module class_constant_pool_parser_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // byte stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] byte_value
  input  logic                           s_axis_tuser,   // [0] start_of_pool
  input  logic                           s_axis_tlast,   // end_of_data
  // result records out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] entry_tag, [23:8] entry_index, [55:24] first_value,
  // [87:56] second_value, [95:88] text_byte, [96] pool_done, [98:97] status, rest zero
  output logic [ccpp_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                           m_axis_tuser,   // [0] is_text_byte
  output logic                           m_axis_tlast,   // last_of_entry
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ccpp_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ccpp_pkg::*;

  logic [CountW-1:0] pool_count_q;
  logic              cfg_wr;

  in_beat_t          in_beat, stage_beat;
  logic              stage_valid;
  logic              out_free;   // result register can take a new record this cycle
  logic              step;       // the staged byte goes through the parser
  logic              res_valid;
  res_t              res, out_res;

  // register port: one register, byte address 0, low address bits ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[AddrW-1] == RegPoolCount);
  assign prdata = (paddr[AddrW-1] == RegPoolCount) ? {16'd0, pool_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_count_q <= '0;
    end else if (cfg_wr) begin
      pool_count_q <= pwdata[CountW-1:0];
    end
  end

  assign in_beat.data  = s_axis_tdata;
  assign in_beat.start = s_axis_tuser;
  assign in_beat.eod   = s_axis_tlast;

  // input beat register
  ccpp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .beat_i  (in_beat),
    .valid_o (stage_valid),
    .take_i  (step),
    .beat_o  (stage_beat)
  );

  // the staged byte advances whenever the result register has room,
  // whether or not it ends up producing a record
  assign step = stage_valid && out_free;

  ccpp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .beat_i       (stage_beat),
    .pool_count_i (pool_count_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  ccpp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  // pack the record onto the output beat
  assign m_axis_tdata = {5'd0, out_res.status, out_res.done, out_res.text,
                         out_res.second, out_res.first, out_res.index, out_res.tag};
  assign m_axis_tuser = out_res.is_text;
  assign m_axis_tlast = out_res.last;
endmodule

// ===== src/ccpp_checker.sv =====
// port-level checks for the constant pool parser, bound to the top level
// depends on ccpp_pkg and class_constant_pool_parser_core
module ccpp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ccpp_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);
  import ccpp_pkg::*;

  // a stalled result holds its beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // non-text records carry no text byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[95:88] == 8'd0)
    else $error("text byte set on a non-text record");

  // a completed pool ends an entry cleanly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[96] |-> m_axis_tlast && m_axis_tdata[98:97] == StOk)
    else $error("pool done without clean entry end");

  // any error ends the entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[98:97] != StOk |-> m_axis_tlast && !m_axis_tdata[96])
    else $error("error record not marked last");

  // text records have zero values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[87:24] == 64'd0)
    else $error("text record carries values");
endmodule

bind class_constant_pool_parser_core ccpp_checker u_ccpp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/tb_class_constant_pool_parser_core.sv =====
// self-checking testbench for the constant pool parser: byte stream in, records out
// a local parser model predicts every record; register writes go through the apb port
// depends on ccpp_pkg and the class_constant_pool_parser_core rtl
module tb_class_constant_pool_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ccpp_pkg::*;

  // a tag value the parser never accepts
  localparam logic [7:0] TagUnknown        = 8'd0;

  localparam logic [AddrW-1:0] PoolCountAddr = AddrW'({RegPoolCount, 2'b00});

  localparam int CycleLimit   = 300000;
  localparam int LongHold     = 400;  // receiver hold-off, long enough to back up the input
  localparam int SettleCycles = 6;    // covers input reg plus result reg

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;  // [7:0] byte_value
  logic                 s_axis_tuser  = 1'b0; // [0] start_of_pool
  logic                 s_axis_tlast  = 1'b0; // end_of_data
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [7:0] entry_tag, [23:8] entry_index, [55:24] first_value, [87:56] second_value,
  // [95:88] text_byte, [96] pool_done, [98:97] status
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;  // [0] is_text_byte
  logic                 m_axis_tlast;  // last_of_entry
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [AddrW-1:0]     paddr   = '0;
  logic [31:0]          pwdata  = '0;
  logic [31:0]          prdata;
  logic                 pready;

  class_constant_pool_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // parser model: its own copy of the pool count and of the parse state
  // ---------------------------------------------------------------------------
  logic [15:0] pm_pool_count = '0;
  phase_e      pm_phase      = PH_TAG;
  logic [7:0]  pm_tag        = '0;
  logic [3:0]  pm_bytes_left = '0;
  logic [63:0] pm_acc        = '0;
  logic [15:0] pm_text_left  = '0;
  logic [15:0] pm_slot       = 16'd1;
  logic        pm_halted     = 1'b0;

  logic [7:0] known_tags [14] = '{TagUtf8, TagInteger, TagFloat, TagLong, TagDouble,
                                  TagClass, TagString, TagFieldref, TagMethodref,
                                  TagIfaceMethodref, TagNameAndType, TagMethodHandle,
                                  TagMethodType, TagInvokeDynamic};

  // field bytes after each tag; zero marks a tag the parser rejects
  function automatic int unsigned tag_field_bytes(input logic [7:0] tag);
    case (tag)
      TagUtf8, TagClass, TagString, TagMethodType: return 2;
      TagInteger, TagFloat, TagFieldref, TagMethodref, TagIfaceMethodref,
      TagNameAndType, TagInvokeDynamic: return 4;
      TagLong, TagDouble: return 8;
      TagMethodHandle: return 3;
      default: return 0;
    endcase
  endfunction

  // record stamped with the tag and slot as they stand right now
  function automatic res_t pool_record(input logic [31:0] v1, input logic [31:0] v2,
                                       input logic [7:0] text, input logic is_text,
                                       input logic last, input logic done,
                                       input logic [1:0] status);
    res_t r;
    r.tag     = pm_tag;
    r.index   = pm_slot;
    r.first   = v1;
    r.second  = v2;
    r.text    = text;
    r.is_text = is_text;
    r.last    = last;
    r.done    = done;
    r.status  = status;
    return r;
  endfunction

  // step to the next slot; reports whether that was the last entry wanted
  function automatic logic close_entry();
    logic fin;
    fin      = ({1'b0, pm_slot} + 17'd1) >= {1'b0, pm_pool_count};
    pm_slot  = pm_slot + 16'd1;
    pm_phase = fin ? PH_IDLE : PH_TAG;
    return fin;
  endfunction

  // one byte through the parser; returns 1 when it yields a record
  function automatic logic parse_byte(input in_beat_t beat, output res_t rec);
    logic [31:0] v1;
    logic [31:0] v2;
    logic        fin;
    v1  = '0;
    v2  = '0;
    rec = '0;
    if (beat.start) begin
      pm_phase      = PH_TAG;
      pm_slot       = 16'd1;
      pm_halted     = 1'b0;
      pm_bytes_left = '0;
      pm_acc        = '0;
      pm_text_left  = '0;
    end
    if (pm_halted || pm_phase == PH_IDLE) return 1'b0;
    case (pm_phase)
      PH_TAG: begin
        // nothing wanted: empty pool or pool count lowered to the slot or below
        if (pm_slot >= pm_pool_count) return 1'b0;
        pm_tag        = beat.data;
        pm_bytes_left = 4'(tag_field_bytes(beat.data));
        pm_acc        = '0;
        if (pm_bytes_left == 0) begin
          rec       = pool_record('0, '0, '0, 1'b0, 1'b1, 1'b0, StBadTag);
          pm_halted = 1'b1;
          return 1'b1;
        end
        pm_phase = PH_FIELDS;
        if (beat.eod) begin
          rec       = pool_record('0, '0, '0, 1'b0, 1'b1, 1'b0, StTrunc);
          pm_halted = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      PH_FIELDS: begin
        pm_acc        = {pm_acc[55:0], beat.data};
        pm_bytes_left = pm_bytes_left - 4'd1;
        if (pm_bytes_left != 0) begin
          if (!beat.eod) return 1'b0;
          rec       = pool_record('0, '0, '0, 1'b0, 1'b1, 1'b0, StTrunc);
          pm_halted = 1'b1;
          return 1'b1;
        end
        case (pm_tag)
          TagInteger, TagFloat: v1 = pm_acc[31:0];
          TagLong, TagDouble: begin
            v1 = pm_acc[63:32];
            v2 = pm_acc[31:0];
          end
          TagMethodHandle: begin
            v1 = {24'd0, pm_acc[23:16]};
            v2 = {16'd0, pm_acc[15:0]};
          end
          TagFieldref, TagMethodref, TagIfaceMethodref, TagNameAndType,
          TagInvokeDynamic: begin
            v1 = {16'd0, pm_acc[31:16]};
            v2 = {16'd0, pm_acc[15:0]};
          end
          default: v1 = {16'd0, pm_acc[15:0]};
        endcase
        // non-empty utf8: header now, text bytes follow
        if (pm_tag == TagUtf8 && v1 != 0) begin
          pm_text_left = v1[15:0];
          pm_phase     = PH_TEXT;
          rec = pool_record(v1, '0, '0, 1'b0, beat.eod, 1'b0, beat.eod ? StTrunc : StOk);
          if (beat.eod) pm_halted = 1'b1;
          return 1'b1;
        end
        // record carries the slot after the advance
        fin = close_entry();
        rec = pool_record(v1, v2, '0, 1'b0, 1'b1, fin, (beat.eod && !fin) ? StTrunc : StOk);
        if (beat.eod && !fin) pm_halted = 1'b1;
        return 1'b1;
      end
      default: begin
        pm_text_left = pm_text_left - 16'd1;
        if (pm_text_left != 0) begin
          rec = pool_record('0, '0, beat.data, 1'b1, beat.eod, 1'b0,
                            beat.eod ? StTrunc : StOk);
          if (beat.eod) pm_halted = 1'b1;
          return 1'b1;
        end
        fin = close_entry();
        rec = pool_record('0, '0, beat.data, 1'b1, 1'b1, fin,
                          (beat.eod && !fin) ? StTrunc : StOk);
        if (beat.eod && !fin) pm_halted = 1'b1;
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // shared state between the processes
  // ---------------------------------------------------------------------------
  in_beat_t byte_feed[$];        // beats waiting for the driver
  res_t     pending_records[$];  // predicted records, oldest first
  in_beat_t beat_on_bus = '0;
  res_t     next_record;
  int       send_gap     = 0;
  int       stall_left   = 0;
  int       hold_left    = 0;
  bit       hold_done    = 1'b0;
  int       results_taken = 0;
  int       mode_left    = 0;
  logic     idle_enable  = 1'b1;
  bit       quiet_tail   = 1'b0;
  int       mismatches   = 0;
  int       cycle_count  = 0;

  // idling comes and goes in stretches; none at all in the closing phase
  always @(posedge clk_i) begin
    if (quiet_tail) begin
      idle_enable <= 1'b0;
    end else if (mode_left == 0) begin
      mode_left = $urandom_range(60, 400);
      idle_enable <= ($urandom_range(0, 3) != 0);
    end else begin
      mode_left--;
    end
  end

  // driver: a beat stays on the bus until taken; every taken beat goes into the model
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (parse_byte(beat_on_bus, next_record)) pending_records.push_back(next_record);
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 11) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (byte_feed.size() > 0) begin
          beat_on_bus = byte_feed.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= beat_on_bus.data;
          s_axis_tuser  <= beat_on_bus.start;
          s_axis_tlast  <= beat_on_bus.eod;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off that backs the block up
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) results_taken++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && !quiet_tail && results_taken >= 250) begin
      hold_done = 1'b1;
      hold_left = LongHold - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic next_check(input res_t want);
    check_field("entry_tag",     32'(want.tag),     32'(m_axis_tdata[7:0]));
    check_field("entry_index",   32'(want.index),   32'(m_axis_tdata[23:8]));
    check_field("first_value",   want.first,        m_axis_tdata[55:24]);
    check_field("second_value",  want.second,       m_axis_tdata[87:56]);
    check_field("text_byte",     32'(want.text),    32'(m_axis_tdata[95:88]));
    check_field("pool_done",     32'(want.done),    32'(m_axis_tdata[96]));
    check_field("status",        32'(want.status),  32'(m_axis_tdata[98:97]));
    check_field("is_text_byte",  32'(want.is_text), 32'(m_axis_tuser));
    check_field("last_of_entry", 32'(want.last),    32'(m_axis_tlast));
  endtask

  // monitor: every taken result beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_records.size() == 0) begin
        $error("result beat with no record predicted: tdata 0x%0h", m_axis_tdata);
        mismatches++;
      end else begin
        next_check(pending_records.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic in_beat_t beat_of(input logic [7:0] data, input logic start = 1'b0,
                                       input logic eod = 1'b0);
    in_beat_t b;
    b.data  = data;
    b.start = start;
    b.eod   = eod;
    return b;
  endfunction

  // everything sent, every record back, and the pipe given time to empty
  task automatic wait_parser_idle();
    do @(negedge clk_i);
    while (byte_feed.size() != 0 || s_axis_tvalid || pending_records.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // apb write: setup then access, register takes it on the access edge
  task automatic set_pool_count(input logic [15:0] count);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PoolCountAddr;
    pwdata  <= {16'd0, count};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pm_pool_count = count;
    @(negedge clk_i);
  endtask

  // one entry with random content; some are cut short and end the pool early
  task automatic add_entry(ref in_beat_t seq[$], output bit cut_short);
    logic [7:0]  tag;
    logic [15:0] len;
    cut_short = 1'b0;
    if ($urandom_range(0, 39) == 0) begin
      do tag = 8'($urandom_range(0, 255));
      while (tag_field_bytes(tag) != 0);
      seq.push_back(beat_of(tag));
      cut_short = 1'b1;
      return;
    end
    tag = ($urandom_range(0, 3) == 0) ? TagUtf8 : known_tags[$urandom_range(0, 13)];
    seq.push_back(beat_of(tag));
    if (tag == TagUtf8) begin
      // a huge string is only started; the next pool start abandons it
      if ($urandom_range(0, 29) == 0) begin
        len = 16'($urandom_range(256, 65535));
        cut_short = 1'b1;
      end else begin
        len = 16'($urandom_range(0, 6));
      end
      seq.push_back(beat_of(len[15:8]));
      seq.push_back(beat_of(len[7:0]));
      repeat (cut_short ? $urandom_range(0, 3) : len) seq.push_back(beat_of(8'($urandom)));
    end else begin
      repeat (tag_field_bytes(tag)) seq.push_back(beat_of(8'($urandom)));
    end
  endtask

  // one pool: mostly well formed, some truncated, abandoned or pure noise
  task automatic add_pool(input int unsigned entries, output int unsigned nbytes);
    in_beat_t    seq[$];
    bit          cut_short;
    int unsigned mode;
    int unsigned pos;
    cut_short = 1'b0;
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      repeat ($urandom_range(1, 8))
        seq.push_back(beat_of(8'($urandom), 1'b0, 1'($urandom_range(0, 1))));
    end else begin
      for (int i = 0; i < entries && !cut_short; i++) add_entry(seq, cut_short);
    end
    if (mode == 1 || mode == 2) begin
      // data runs out at a random byte
      pos = $urandom_range(0, seq.size() - 1);
      while (seq.size() > pos + 1) void'(seq.pop_back());
      seq[pos].eod = 1'b1;
    end else if (mode == 3) begin
      // abandoned mid-way; the next start takes over
      pos = $urandom_range(0, seq.size() - 1);
      while (seq.size() > pos + 1) void'(seq.pop_back());
    end else if (mode != 0 && !cut_short) begin
      if ($urandom_range(0, 1)) seq[seq.size() - 1].eod = 1'b1;
      // trailing bytes after completion are ignored
      repeat ($urandom_range(0, 2))
        seq.push_back(beat_of(8'($urandom), 1'b0, 1'($urandom_range(0, 1))));
    end
    seq[0].start = 1'b1;
    nbytes = seq.size();
    foreach (seq[i]) byte_feed.push_back(seq[i]);
  endtask

  task automatic run_phase(input logic [15:0] count, input int unsigned budget);
    int unsigned fed;
    int unsigned n;
    int unsigned entries;
    set_pool_count(count);
    fed = 0;
    while (fed < budget) begin
      // small counts give complete pools; large ones never finish, so keep them short
      entries = (count >= 2 && count <= 16) ? 32'(count) - 32'd1 : $urandom_range(1, 6);
      add_pool(entries, n);
      fed += n;
    end
    wait_parser_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty pool straight after reset: all of this is ignored
    byte_feed.push_back(beat_of(TagClass, 1'b1));
    byte_feed.push_back(beat_of(8'h01));
    byte_feed.push_back(beat_of(8'h02, 1'b0, 1'b1));
    wait_parser_idle();

    set_pool_count(16'd3);
    // class at the field extremes, one-byte utf8, then a stray byte after done
    byte_feed.push_back(beat_of(TagClass, 1'b1));
    byte_feed.push_back(beat_of(8'hFF));
    byte_feed.push_back(beat_of(8'hFF));
    byte_feed.push_back(beat_of(TagUtf8));
    byte_feed.push_back(beat_of(8'h00));
    byte_feed.push_back(beat_of(8'h01));
    byte_feed.push_back(beat_of(8'h80));
    byte_feed.push_back(beat_of(8'h55, 1'b0, 1'b1));
    // unknown tag halts; next byte ignored
    byte_feed.push_back(beat_of(TagUnknown, 1'b1));
    byte_feed.push_back(beat_of(TagInteger));
    // data ends inside a long's fields
    byte_feed.push_back(beat_of(TagLong, 1'b1));
    byte_feed.push_back(beat_of(8'h12, 1'b0, 1'b1));
    // data ends on the tag byte
    byte_feed.push_back(beat_of(TagInteger, 1'b1, 1'b1));
    // data ends right after a complete entry while more are wanted
    byte_feed.push_back(beat_of(TagString, 1'b1));
    byte_feed.push_back(beat_of(8'h00));
    byte_feed.push_back(beat_of(8'hFF, 1'b0, 1'b1));
    // data ends on a utf8 header
    byte_feed.push_back(beat_of(TagUtf8, 1'b1));
    byte_feed.push_back(beat_of(8'h00));
    byte_feed.push_back(beat_of(8'h03, 1'b0, 1'b1));
    // data ends inside utf8 text
    byte_feed.push_back(beat_of(TagUtf8, 1'b1));
    byte_feed.push_back(beat_of(8'h00));
    byte_feed.push_back(beat_of(8'h02));
    byte_feed.push_back(beat_of(8'h61, 1'b0, 1'b1));
    wait_parser_idle();

    // random part; the count changes between phases while mid-pool state persists
    run_phase(16'd2, 320);
    run_phase(16'd5, 320);
    run_phase(16'hFFFF, 250);
    run_phase(16'd1, 30);
    run_phase(16'($urandom_range(6, 12)), 320);
    run_phase(16'd3, 280);
    run_phase(16'($urandom_range(13, 65534)), 150);
    run_phase(16'd0, 30);
    quiet_tail = 1'b1;
    run_phase(16'd4, 150);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ccpp_pkg.sv
src/ccpp_in_reg.sv
src/ccpp_parse.sv
src/ccpp_out_reg.sv
src/class_constant_pool_parser_core.sv
src/ccpp_checker.sv
dv/tb_class_constant_pool_parser_core.sv
